[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define HIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication.
`define HIC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

[src/hic_pkg.sv]
package hic_pkg;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned AXES    = 3;

  localparam logic [TIME_W-1:0] CAPTURE_LEN_RST = 20'd30000;
  localparam logic [VAL_W-1:0]  POOR_LIMIT_RST  = 16'd500;
  localparam logic [TIME_W-1:0] ELAPSED_MAX     = 20'hFFFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 16'hFFFF;
  localparam logic signed [VAL_W-1:0] MIN_RST   = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] MAX_RST   = 16'sh8000;

  // configuration register indexes
  localparam logic CFG_CAPTURE_LEN = 1'b0;
  localparam logic CFG_POOR_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_START  = 2'd2,
    REQ_CLEAR  = 2'd3
  } hic_req_t;

  // per-item actions from the controller to the axis trackers
  typedef struct packed {
    logic sample_upd;
    logic start;
    logic close;
    logic clear;
    logic cnt_zero;   // no samples after this word
    logic show;       // spread goes out on this word
  } hic_ctl_t;

  typedef struct packed {
    logic                     capture_running;
    logic                     have_calibration;
    logic                     capture_done;
    logic                     poor_axis;
    logic signed [VAL_W-1:0]  offset_x;
    logic signed [VAL_W-1:0]  offset_y;
    logic signed [VAL_W-1:0]  offset_z;
    logic [VAL_W-1:0]         spread_x;
    logic [VAL_W-1:0]         spread_y;
    logic [VAL_W-1:0]         spread_z;
    logic [TIME_W-1:0]        time_left_ms;
    logic [CNT_W-1:0]         samples_taken;
  } hic_res_t;

endpackage

[src/magnetometer_hard_iron_calibrator.sv]
// Hard-iron calibrator using the per-axis min/max method. Words carry a tick,
// a sample, a start or a clear request and each returns one status word.
// A word is taken into the input register when accepted; once the result
// register is free or being emptied, the state update lands and the result
// register loads, raising out_valid. One word is accepted every cycle while
// in_stall is low, and the input register still takes one word while a
// result is stalled. Offsets are floor((max+min)/2); spreads are max-min.
// Config writes must be made while no word is in flight.
module magnetometer_hard_iron_calibrator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [hic_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic signed [hic_pkg::VAL_W-1:0]  in_sample_x,
  input  logic signed [hic_pkg::VAL_W-1:0]  in_sample_y,
  input  logic signed [hic_pkg::VAL_W-1:0]  in_sample_z,
  input  logic                              in_sample_overflow,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_capture_running,
  output logic                              out_have_calibration,
  output logic                              out_capture_done,
  output logic                              out_poor_axis,
  output logic signed [hic_pkg::VAL_W-1:0]  out_offset_x,
  output logic signed [hic_pkg::VAL_W-1:0]  out_offset_y,
  output logic signed [hic_pkg::VAL_W-1:0]  out_offset_z,
  output logic [hic_pkg::VAL_W-1:0]         out_spread_x,
  output logic [hic_pkg::VAL_W-1:0]         out_spread_y,
  output logic [hic_pkg::VAL_W-1:0]         out_spread_z,
  output logic [hic_pkg::TIME_W-1:0]        out_time_left_ms,
  output logic [hic_pkg::CNT_W-1:0]         out_samples_taken
);

  logic [hic_pkg::TIME_W-1:0]       capture_len_r;
  logic [hic_pkg::VAL_W-1:0]        poor_limit_r;

  logic                             in_valid_r;
  logic [1:0]                       req_r;
  logic signed [hic_pkg::VAL_W-1:0] smp_r [hic_pkg::AXES];
  logic                             ovf_r;

  logic                             out_valid_r;
  hic_pkg::hic_res_t                res_r, res_nxt;

  logic                             advance;
  hic_pkg::hic_ctl_t                ctl;
  logic                             running_nxt, calib_nxt, done;
  logic [hic_pkg::TIME_W-1:0]       time_left;
  logic [hic_pkg::CNT_W-1:0]        count_nxt;
  logic signed [hic_pkg::VAL_W-1:0] offset [hic_pkg::AXES];
  logic [hic_pkg::VAL_W-1:0]        spread [hic_pkg::AXES];
  logic [hic_pkg::AXES-1:0]         axis_poor;

  // a word moves on when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_len_r <= hic_pkg::CAPTURE_LEN_RST;
      poor_limit_r  <= hic_pkg::POOR_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hic_pkg::CFG_CAPTURE_LEN: capture_len_r <= cfg_wdata;
        hic_pkg::CFG_POOR_LIMIT:  poor_limit_r  <= cfg_wdata[hic_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r    <= in_req_type;
      smp_r[0] <= in_sample_x;
      smp_r[1] <= in_sample_y;
      smp_r[2] <= in_sample_z;
      ovf_r    <= in_sample_overflow;
    end
  end

  hic_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (advance),
    .req_type        (req_r),
    .sample_overflow (ovf_r),
    .capture_len     (capture_len_r),
    .ctl             (ctl),
    .running_nxt     (running_nxt),
    .calib_nxt       (calib_nxt),
    .done            (done),
    .time_left       (time_left),
    .count_nxt       (count_nxt)
  );

  for (genvar a = 0; a < hic_pkg::AXES; a++) begin : g_axis
    hic_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .sample     (smp_r[a]),
      .poor_limit (poor_limit_r),
      .offset_nxt (offset[a]),
      .spread     (spread[a]),
      .poor       (axis_poor[a])
    );
  end

  always_comb begin
    res_nxt.capture_running  = running_nxt;
    res_nxt.have_calibration = calib_nxt;
    res_nxt.capture_done     = done;
    res_nxt.poor_axis        = done && (ctl.cnt_zero || (|axis_poor));
    res_nxt.offset_x         = offset[0];
    res_nxt.offset_y         = offset[1];
    res_nxt.offset_z         = offset[2];
    res_nxt.spread_x         = spread[0];
    res_nxt.spread_y         = spread[1];
    res_nxt.spread_z         = spread[2];
    res_nxt.time_left_ms     = time_left;
    res_nxt.samples_taken    = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_capture_running  = res_r.capture_running;
  assign out_have_calibration = res_r.have_calibration;
  assign out_capture_done     = res_r.capture_done;
  assign out_poor_axis        = res_r.poor_axis;
  assign out_offset_x         = res_r.offset_x;
  assign out_offset_y         = res_r.offset_y;
  assign out_offset_z         = res_r.offset_z;
  assign out_spread_x         = res_r.spread_x;
  assign out_spread_y         = res_r.spread_y;
  assign out_spread_z         = res_r.spread_z;
  assign out_time_left_ms     = res_r.time_left_ms;
  assign out_samples_taken    = res_r.samples_taken;

endmodule

[src/hic_ctrl.sv]
module hic_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [1:0]                  req_type,
  input  logic                        sample_overflow,
  input  logic [hic_pkg::TIME_W-1:0]  capture_len,
  output hic_pkg::hic_ctl_t           ctl,
  output logic                        running_nxt,
  output logic                        calib_nxt,
  output logic                        done,
  output logic [hic_pkg::TIME_W-1:0]  time_left,
  output logic [hic_pkg::CNT_W-1:0]   count_nxt
);

  logic                       running_r;
  logic                       calib_r;
  logic [hic_pkg::TIME_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [hic_pkg::CNT_W-1:0]  count_r;
  hic_pkg::hic_req_t          req;

  assign req = hic_pkg::hic_req_t'(req_type);
  assign elapsed_inc = (elapsed_r == hic_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    running_nxt    = running_r;
    calib_nxt      = calib_r;
    elapsed_nxt    = elapsed_r;
    count_nxt      = count_r;
    done           = 1'b0;
    ctl.sample_upd = 1'b0;
    ctl.start      = 1'b0;
    ctl.close      = 1'b0;
    ctl.clear      = 1'b0;
    if (fire) begin
      case (req)
        hic_pkg::REQ_TICK: begin
          if (running_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= capture_len) begin
              done        = 1'b1;
              ctl.close   = 1'b1;
              running_nxt = 1'b0;
              calib_nxt   = 1'b1;
            end
          end
        end
        hic_pkg::REQ_SAMPLE: begin
          if (running_r && !sample_overflow) begin
            ctl.sample_upd = 1'b1;
            if (count_r != hic_pkg::COUNT_MAX) count_nxt = count_r + 1'b1;
          end
        end
        hic_pkg::REQ_START: begin
          // a start during an open window is dropped
          if (!running_r) begin
            ctl.start   = 1'b1;
            count_nxt   = '0;
            elapsed_nxt = '0;
            running_nxt = 1'b1;
          end
        end
        hic_pkg::REQ_CLEAR: begin
          ctl.clear = 1'b1;
          calib_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    ctl.cnt_zero = (count_nxt == '0);
    ctl.show     = (running_nxt || done) && (count_nxt != '0);
    time_left    = (running_nxt && (elapsed_nxt < capture_len)) ?
                   capture_len - elapsed_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      calib_r   <= 1'b0;
      elapsed_r <= '0;
      count_r   <= '0;
    end else begin
      running_r <= running_nxt;
      calib_r   <= calib_nxt;
      elapsed_r <= elapsed_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

[src/hic_axis.sv]
module hic_axis (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hic_pkg::hic_ctl_t                 ctl,
  input  logic signed [hic_pkg::VAL_W-1:0]  sample,
  input  logic [hic_pkg::VAL_W-1:0]         poor_limit,
  output logic signed [hic_pkg::VAL_W-1:0]  offset_nxt,
  output logic [hic_pkg::VAL_W-1:0]         spread,
  output logic                              poor
);

  logic signed [hic_pkg::VAL_W-1:0] min_r, min_nxt;
  logic signed [hic_pkg::VAL_W-1:0] max_r, max_nxt;
  logic signed [hic_pkg::VAL_W-1:0] off_r;
  logic signed [hic_pkg::VAL_W:0]   sum;
  logic [hic_pkg::VAL_W-1:0]        span;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.start) begin
      min_nxt = hic_pkg::MIN_RST;
      max_nxt = hic_pkg::MAX_RST;
    end else if (ctl.sample_upd) begin
      if (sample < min_r) min_nxt = sample;
      if (sample > max_r) max_nxt = sample;
    end
  end

  // floor of the midpoint: drop the low bit of the 17-bit sum
  assign sum = {max_r[hic_pkg::VAL_W-1], max_r} + {min_r[hic_pkg::VAL_W-1], min_r};

  always_comb begin
    offset_nxt = off_r;
    if (ctl.clear) begin
      offset_nxt = '0;
    end else if (ctl.close) begin
      offset_nxt = ctl.cnt_zero ? '0 : sum[hic_pkg::VAL_W:1];
    end
  end

  assign span   = max_nxt - min_nxt;
  assign spread = ctl.show ? span : '0;
  assign poor   = (spread < poor_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= hic_pkg::MIN_RST;
      max_r <= hic_pkg::MAX_RST;
      off_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      off_r <= offset_nxt;
    end
  end

endmodule

[src/hic_checker.sv]
`include "assert_macros.svh"

module hic_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_capture_running,
  input logic                              out_have_calibration,
  input logic                              out_capture_done,
  input logic                              out_poor_axis,
  input logic signed [hic_pkg::VAL_W-1:0]  out_offset_x,
  input logic [hic_pkg::VAL_W-1:0]         out_spread_x,
  input logic [hic_pkg::VAL_W-1:0]         out_spread_y,
  input logic [hic_pkg::VAL_W-1:0]         out_spread_z,
  input logic [hic_pkg::TIME_W-1:0]        out_time_left_ms
);

  // the word that closes a window reports it closed and calibrated
  `HIC_ASSERT(a_done_closes, out_valid && out_capture_done |-> !out_capture_running && out_have_calibration, "done word with window open or no calibration")

  `HIC_ASSERT(a_poor_only_done, out_valid && out_poor_axis |-> out_capture_done, "poor flag outside a done word")

  // idle words show no spread and no remaining time
  `HIC_ASSERT(a_idle_quiet, out_valid && !out_capture_running && !out_capture_done |-> out_time_left_ms == '0 && out_spread_x == '0 && out_spread_y == '0 && out_spread_z == '0, "idle word with spread or time left")

  `HIC_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_offset_x) && $stable(out_time_left_ms), "stalled result word changed")

endmodule

bind magnetometer_hard_iron_calibrator hic_checker u_hic_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_capture_running  (out_capture_running),
  .out_have_calibration (out_have_calibration),
  .out_capture_done     (out_capture_done),
  .out_poor_axis        (out_poor_axis),
  .out_offset_x         (out_offset_x),
  .out_spread_x         (out_spread_x),
  .out_spread_y         (out_spread_y),
  .out_spread_z         (out_spread_z),
  .out_time_left_ms     (out_time_left_ms)
);
